// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("forbidden condition");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hdl/actr_pkg.sv =====
// ---------------------------------------------------------------------------
// AES-128 CTR package
// Shared constants, S-box and round helper functions.
// ---------------------------------------------------------------------------
package actr_pkg;
	localparam int BlockBytes = 16;
	localparam int RkDepth    = 44;
	localparam int KsDepth    = 16;

	typedef enum logic [1:0] {
		REG_KEY_HIGH  = 2'd0,
		REG_KEY_LOW   = 2'd1,
		REG_CTR_HIGH  = 2'd2,
		REG_CTR_LOW   = 2'd3
	} reg_idx_t;

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[a];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

	// State in FIPS byte order: byte 0 in bits 127:120.
	function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, x;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
		for (int rr = 0; rr < 4; rr++)
			for (int c = 0; c < 4; c++) t[rr+4*c] = b[rr+4*((c+rr)%4)];
		if (!last) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				x = a0 ^ a1 ^ a2 ^ a3;
				t[4*c]   = a0 ^ x ^ xtime(a0 ^ a1);
				t[4*c+1] = a1 ^ x ^ xtime(a1 ^ a2);
				t[4*c+2] = a2 ^ x ^ xtime(a2 ^ a3);
				t[4*c+3] = a3 ^ x ^ xtime(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) r[127-8*i -: 8] = t[i];
		return r;
	endfunction
endpackage

// ===== hdl/actr_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module actr_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hdl/actr_core.sv =====
// ---------------------------------------------------------------------------
// AES-128 keystream engine
// Expands the key into the round-key RAM one word a cycle, then runs ten
// rounds reading four words per round back, and writes keystream bytes.
// ---------------------------------------------------------------------------
module actr_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] key,
	input  logic [127:0] ctr,
	output logic         done,
	output logic         ks_we,
	output logic [3:0]   ks_waddr,
	output logic [7:0]   ks_wdata
);
	import actr_pkg::*;

	typedef enum logic [2:0] {ST_IDLE, ST_EXP, ST_RD, ST_RND, ST_OUT} st_t;

	st_t          st_q;
	logic [5:0]   widx_q;     // key word being produced
	logic [31:0]  w_q [4];    // last four key words (sliding window)
	logic [3:0]   round_q;
	logic [1:0]   col_q;
	logic [127:0] s_q;
	logic [95:0]  rk_q;
	logic [3:0]   obyte_q;
	logic [7:0]   rcon_q;

	logic         rk_we;
	logic [5:0]   rk_waddr, rk_raddr;
	logic [31:0]  rk_wdata, rk_rdata, wnew, tw;

	always_comb begin
		tw = w_q[3];
		if (widx_q[1:0] == 2'd0) tw = sub_word({tw[23:0], tw[31:24]}) ^ {rcon_q, 24'h0};
		wnew = w_q[0] ^ tw;
	end

	assign rk_we    = (st_q == ST_EXP);
	assign rk_waddr = widx_q;
	assign rk_wdata = wnew;
	assign rk_raddr = {round_q, col_q};

	actr_ram #(.Width(32), .Depth(RkDepth)) u_rk (
		.clk, .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
		.raddr(rk_raddr), .rdata(rk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			done  <= 1'b0;
			ks_we <= 1'b0;
		end else begin
			done  <= (st_q == ST_OUT) && (obyte_q == 4'd15);
			ks_we <= (st_q == ST_OUT);
			case (st_q)
				ST_IDLE: begin
					if (start) begin
						// Round 0 key is the key itself; words 4..43 go to RAM.
						w_q[0] <= key[127:96]; w_q[1] <= key[95:64];
						w_q[2] <= key[63:32];  w_q[3] <= key[31:0];
						s_q    <= ctr ^ key;
						widx_q <= 6'd4;
						rcon_q <= 8'h01;
						st_q   <= ST_EXP;
					end
				end
				ST_EXP: begin
					w_q[0] <= w_q[1]; w_q[1] <= w_q[2]; w_q[2] <= w_q[3]; w_q[3] <= wnew;
					if (widx_q[1:0] == 2'd0) rcon_q <= xtime(rcon_q);
					if (widx_q == 6'(RkDepth - 1)) begin
						round_q <= 4'd1;
						col_q   <= 2'd0;
						st_q    <= ST_RD;
					end
					widx_q <= widx_q + 6'd1;
				end
				ST_RD: begin
					// Address col 0 presented; advance to collect.
					col_q <= 2'd1;
					st_q  <= ST_RND;
				end
				ST_RND: begin
					rk_q  <= {rk_q[63:0], rk_rdata};
					// Hold col at zero once the fourth word is in.
					col_q <= (col_q == 2'd0) ? 2'd0 : col_q + 2'd1;
					if (col_q == 2'd0) begin
						s_q <= enc_round(s_q, round_q == 4'd10) ^ {rk_q, rk_rdata};
						if (round_q == 4'd10) begin
							obyte_q <= 4'd0;
							st_q    <= ST_OUT;
						end else begin
							round_q <= round_q + 4'd1;
							st_q    <= ST_RD;
						end
					end
				end
				ST_OUT: begin
					ks_waddr <= obyte_q;
					ks_wdata <= s_q[127 - 8*obyte_q -: 8];
					obyte_q  <= obyte_q + 4'd1;
					if (obyte_q == 4'd15) st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/aes128_ctr_stream_cipher_top.sv =====
// ---------------------------------------------------------------------------
// AES-128 CTR byte-stream cipher
// Encrypts or decrypts bytes by XOR with an AES-128 counter keystream.
// ---------------------------------------------------------------------------
// Usage:
//  s_axis carries one byte a request; tuser is the message-start flag, which
//  reloads the counter from the counter_init registers and restarts the block.
//  m_axis returns one byte per input byte, in order.
//  cfg writes registers: 0 key_high, 1 key_low, 2 counter_init_high,
//  3 counter_init_low. Write only while the stream is idle.
//  At a block start, the key is expanded into the round-key RAM, then ten
//  rounds follow, each reading four words from that RAM port, then the
//  16 keystream bytes are written to the keystream RAM. Other bytes pass
//  through the keystream RAM read, then the XOR into the output register.
//  Reset clears the counter and byte position; no clearing pass is needed.
//  A stalled m_axis holds the output register; s_axis waits until it drains.
// ---------------------------------------------------------------------------
module aes128_ctr_stream_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_in
	input  logic        s_axis_tuser,  // [0] msg_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // [7:0] data_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	import actr_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [1:0] {ST_IDLE, ST_GEN, ST_RD, ST_XOR} st_t;

	st_t          st_q;
	logic [127:0] key_q, cinit_q, ctr_q;
	logic [3:0]   pos_q;
	logic [7:0]   din_q;
	logic         gen_start, gen_done, ks_we;
	logic [3:0]   ks_waddr;
	logic [7:0]   ks_wdata, ks_rdata;
	logic         in_fire;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (st_q == ST_IDLE) && !m_axis_tvalid;
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign gen_start     = in_fire && (s_axis_tuser || pos_q == 4'd0);

	actr_core u_core (
		.clk, .arst_n, .start(gen_start), .key(key_q),
		.ctr(s_axis_tuser ? cinit_q : ctr_q),
		.done(gen_done), .ks_we, .ks_waddr, .ks_wdata
	);

	actr_ram #(.Width(8), .Depth(KsDepth)) u_ks (
		.clk, .we(ks_we), .waddr(ks_waddr), .wdata(ks_wdata),
		.raddr(pos_q), .rdata(ks_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= '0;
			cinit_q <= '0;
			ctr_q   <= '0;
			pos_q   <= '0;
			st_q    <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_KEY_HIGH: key_q[127:64]   <= cfg_data;
					REG_KEY_LOW:  key_q[63:0]     <= cfg_data;
					REG_CTR_HIGH: cinit_q[127:64] <= cfg_data;
					REG_CTR_LOW:  cinit_q[63:0]   <= cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (in_fire) begin
						din_q <= s_axis_tdata;
						if (s_axis_tuser) begin
							// reload counter, restart block
							ctr_q <= cinit_q;
							pos_q <= 4'd0;
							st_q  <= ST_GEN;
						end else if (pos_q == 4'd0) st_q <= ST_GEN;
						else st_q <= ST_RD;
					end
				end
				ST_GEN: if (gen_done) st_q <= ST_RD;
				ST_RD:  st_q <= ST_XOR;
				ST_XOR: begin
					m_axis_tdata  <= din_q ^ ks_rdata;
					m_axis_tvalid <= 1'b1;
					pos_q <= pos_q + 4'd1;
					if (pos_q == 4'(BlockBytes - 1)) ctr_q <= ctr_q + 128'd1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_NEVER(a_out_overrun, clk, arst_n, st_q == ST_XOR && m_axis_tvalid)
	`ASSERT_CLK(a_fire_leaves_idle, clk, arst_n, in_fire |=> st_q != ST_IDLE)
	`ASSERT_NEVER(a_ks_write_outside_gen, clk, arst_n, ks_we && st_q != ST_GEN)
	`ASSERT_CLK(a_ctr_step, clk, arst_n,
		(st_q == ST_XOR && pos_q == 4'd15) |=> ctr_q == $past(ctr_q) + 128'd1)
endmodule
